### design/positional_list_engine_top_assert.svh
// Assertion macros for the positional list engine top level.
`ifndef POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define PLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ple_pkg.sv
// Shared types and constants for the positional list engine.
package ple_pkg;

  localparam int unsigned PLE_CAPACITY = 64;
  localparam int unsigned PLE_OP_W     = 3;
  localparam int unsigned PLE_POS_W    = 7;
  localparam int unsigned PLE_DATA_W   = 32;
  localparam int unsigned PLE_STATUS_W = 2;
  localparam int unsigned PLE_FIDX_W   = 6;
  localparam int unsigned PLE_COUNT_W  = 7;

  typedef enum logic [PLE_OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_READ   = 3'd2,
    OP_REMOVE = 3'd3,
    OP_FIND   = 3'd4,
    OP_CLEAR  = 3'd5
  } ple_op_t;

  typedef enum logic [PLE_STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } ple_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ_WAIT,
    S_INS_STEP,
    S_INS_MOVE,
    S_RM_STEP,
    S_RM_MOVE,
    S_FIND
  } ple_state_t;

  typedef struct packed {
    logic [PLE_OP_W-1:0]          operation;
    logic [PLE_POS_W-1:0]         position;
    logic signed [PLE_DATA_W-1:0] value;
  } ple_in_t;

  typedef struct packed {
    logic [PLE_STATUS_W-1:0]      status;
    logic signed [PLE_DATA_W-1:0] read_value;
    logic [PLE_FIDX_W-1:0]        found_index;
    logic [PLE_COUNT_W-1:0]       element_count;
  } ple_out_t;

endpackage

### design/ple_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module ple_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/ple_ctrl.sv
// Request sequencer: decodes items and walks the element RAM to shift or search.
module ple_ctrl import ple_pkg::*; #(
  parameter int unsigned CAPACITY = PLE_CAPACITY,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  ple_in_t               in_data,
  output logic                  out_valid,
  output ple_out_t              out_data,
  output logic                  ram_we,
  output logic [AW-1:0]         ram_waddr,
  output logic [PLE_DATA_W-1:0] ram_wdata,
  output logic                  ram_re,
  output logic [AW-1:0]         ram_raddr,
  input  logic [PLE_DATA_W-1:0] ram_rdata
);

  ple_state_t state_r, state_nxt;

  logic [PLE_OP_W-1:0]   op_r, op_nxt;
  logic [PLE_POS_W-1:0]  pos_r, pos_nxt;
  logic [PLE_DATA_W-1:0] val_r, val_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         tgt_r, tgt_nxt;
  logic                  chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]         chk_idx_r, chk_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ple_out_t              out_r, out_nxt;

  logic                  pos_gt, pos_ge, full, ins_done, rm_last, hit, more;
  logic                  fin;
  ple_status_t           fin_status;
  logic [PLE_DATA_W-1:0] fin_rd;
  logic [PLE_FIDX_W-1:0] fin_fidx;

  // Decision terms shared by the next-state and datapath blocks
  always_comb begin
    pos_gt   = pos_r > PLE_POS_W'(cnt_r);
    pos_ge   = pos_r >= PLE_POS_W'(cnt_r);
    full     = cnt_r == CW'(CAPACITY);
    ins_done = idx_r == tgt_r;
    rm_last  = (idx_r + CW'(1)) == cnt_r;
    hit      = chk_vld_r && (ram_rdata == val_r);
    more     = idx_r < cnt_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (op_r)
          OP_APPEND: state_nxt = full ? S_IDLE : S_INS_STEP;
          OP_INSERT: state_nxt = (pos_gt || full) ? S_IDLE : S_INS_STEP;
          OP_READ:   state_nxt = pos_ge ? S_IDLE : S_READ_WAIT;
          OP_REMOVE: state_nxt = pos_ge ? S_IDLE : S_RM_STEP;
          OP_FIND:   state_nxt = S_FIND;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_READ_WAIT: state_nxt = S_IDLE;
      S_INS_STEP:  state_nxt = ins_done ? S_IDLE : S_INS_MOVE;
      S_INS_MOVE:  state_nxt = S_INS_STEP;
      S_RM_STEP:   state_nxt = rm_last ? S_IDLE : S_RM_MOVE;
      S_RM_MOVE:   state_nxt = S_RM_STEP;
      S_FIND:      state_nxt = (hit || !more) ? S_IDLE : S_FIND;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt      = op_r;
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    tgt_nxt     = tgt_r;
    chk_vld_nxt = 1'b0;
    chk_idx_nxt = chk_idx_r;
    ram_we      = 1'b0;
    ram_waddr   = AW'(idx_r);
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = AW'(idx_r);
    fin         = 1'b0;
    fin_status  = ST_OK;
    fin_rd      = '0;
    fin_fidx    = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt  = in_data.operation;
          pos_nxt = in_data.position;
          val_nxt = in_data.value;
        end
      end
      S_DECODE: begin
        case (op_r)
          OP_APPEND: begin
            if (full) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end else begin
              idx_nxt = cnt_r;
              tgt_nxt = cnt_r;
            end
          end
          OP_INSERT: begin
            // bad position wins over full
            if (pos_gt) begin
              fin        = 1'b1;
              fin_status = ST_BADPOS;
            end else if (full) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end else begin
              idx_nxt = cnt_r;
              tgt_nxt = CW'(pos_r);
            end
          end
          OP_READ: begin
            if (pos_ge) begin
              fin        = 1'b1;
              fin_status = ST_BADPOS;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = AW'(pos_r);
            end
          end
          OP_REMOVE: begin
            if (pos_ge) begin
              fin        = 1'b1;
              fin_status = ST_BADPOS;
            end else begin
              idx_nxt = CW'(pos_r);
            end
          end
          OP_FIND: begin
            idx_nxt = '0;
          end
          OP_CLEAR: begin
            cnt_nxt = '0;
            fin     = 1'b1;
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_READ_WAIT: begin
        fin    = 1'b1;
        fin_rd = ram_rdata;
      end
      S_INS_STEP: begin
        // walk down from the tail; the new item lands once the gap reaches its slot
        if (ins_done) begin
          ram_we    = 1'b1;
          ram_wdata = val_r;
          cnt_nxt   = cnt_r + CW'(1);
          fin       = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(idx_r - CW'(1));
        end
      end
      S_INS_MOVE: begin
        ram_we  = 1'b1;
        idx_nxt = idx_r - CW'(1);
      end
      S_RM_STEP: begin
        if (rm_last) begin
          cnt_nxt = cnt_r - CW'(1);
          fin     = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(idx_r + CW'(1));
        end
      end
      S_RM_MOVE: begin
        ram_we  = 1'b1;
        idx_nxt = idx_r + CW'(1);
      end
      S_FIND: begin
        // one read issued per cycle, compared the cycle after
        if (hit) begin
          fin      = 1'b1;
          fin_fidx = PLE_FIDX_W'(chk_idx_r);
        end else if (more) begin
          ram_re      = 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = AW'(idx_r);
          idx_nxt     = idx_r + CW'(1);
        end else begin
          fin        = 1'b1;
          fin_status = ST_NOTFOUND;
        end
      end
      default: begin
      end
    endcase

    out_valid_nxt = fin;
    out_nxt       = out_r;
    if (fin) begin
      out_nxt.status        = fin_status;
      out_nxt.read_value    = fin_rd;
      out_nxt.found_index   = fin_fidx;
      out_nxt.element_count = PLE_COUNT_W'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    idx_r     <= idx_nxt;
    tgt_r     <= tgt_nxt;
    chk_idx_r <= chk_idx_nxt;
    out_r     <= out_nxt;
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### design/positional_list_engine_top.sv
// Positional list engine top level: sequencer plus one element RAM.
// Clear, spare codes and errors finish in decode; append and read after one RAM access; insert
// and remove after shifting the elements from the position on; find after reading to a match or
// the tail. Each shifted element costs one RAM read and one write on the single RAM port pair.
// A new item is taken in the cycle the result strobe is up; the receiver cannot stall.
// Synchronous reset empties the list; RAM contents are not cleared.
`include "positional_list_engine_top_assert.svh"

module positional_list_engine_top import ple_pkg::*; #(
  parameter int unsigned CAPACITY = PLE_CAPACITY
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ple_in_t  in_data,
  output logic     out_valid,
  output ple_out_t out_data
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam logic [PLE_COUNT_W-1:0] CAP_COUNT = PLE_COUNT_W'(CAPACITY);

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [PLE_DATA_W-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [PLE_DATA_W-1:0] ram_rdata;
  logic [PLE_COUNT_W-1:0] res_count;
  logic                   res_full;

  ple_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ple_ram #(
    .WIDTH (PLE_DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_count = out_data.element_count;
  assign res_full  = out_valid && (out_data.status == ST_FULL);

  `PLE_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `PLE_ASSERT_IMP(a_result_idle, out_valid, !busy, "result strobe while sequencer busy")
  `PLE_ASSERT_IMP(a_count_range, out_valid, res_count <= CAP_COUNT, "count above capacity")
  `PLE_ASSERT_IMP(a_full_count, res_full, res_count == CAP_COUNT, "full status with room left")

endmodule
